### design/assert_macros.svh
// Assertion macros used by the allocator top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising clock edge outside reset
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Implication whose consequent is checked in the cycle after the antecedent
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### design/ffba_pkg.sv
// Package: types, constants and status codes for the first-fit allocator
package ffba_pkg;

    localparam int TABLE_ENTRIES = 8192;
    localparam int PAGE_COUNT    = 16;
    localparam longint PAGE_BYTES = 64'd4194304;

    localparam int SIZE_W = 23;
    localparam int ADDR_W = 26;
    localparam int XADDR_W = 40;    // wide enough for any page end without wrap

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_BAD_SIZE  = 2'd1,
        ST_NO_SPACE  = 2'd2,
        ST_NOT_ALLOC = 2'd3
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHECK,
        S_SCAN_RD,
        S_SCAN_WAIT,
        S_SCAN_EVAL,
        S_TAIL,
        S_NEWPAGE,
        S_SHIFT_RD,
        S_SHIFT_WAIT,
        S_SHIFT_WR,
        S_PLACE,
        S_DONE
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic load;        // capture request
        logic scan_start;  // i <- 0, p <- 0
        logic rd_scan;     // read entry i
        logic eval;        // consume scanned entry
        logic scan_next;   // advance i and p
        logic newpage;     // set p to next page base and open it
        logic ins_init;    // k <- count for insertion shift
        logic del_init;    // k <- i for removal shift
        logic rd_shift;    // read shift source entry
        logic wr_shift;    // write shifted entry
        logic shift_next;  // step k
        logic wr_place;    // write new entry at i
        logic wr_marker;   // write page marker at count
        logic cnt_inc;
        logic cnt_dec;
        logic set_result;
        t_status result;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic is_free;
        logic bad_size;
        logic too_big;
        logic any_page;
        logic scan_end;     // i == count
        logic gap_fit;      // block fits before entry i
        logic free_hit;     // entry i matches the free address
        logic tail_fit;     // block fits after last entry
        logic full1;        // no room for one entry
        logic full2;        // no room for two entries
        logic pages_full;
        logic ins_done;     // k == i
        logic del_done;     // k + 1 >= count
    } t_stat;

endpackage

### design/ffba_ram.sv
// Generic single-port RAM with registered read
module ffba_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule

### design/ffba_ctrl.sv
// Controller: sequences scan, shift and write steps of each request
module ffba_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    output logic              o_valid,
    input  logic              i_ready,
    input  ffba_pkg::t_stat   i_stat,
    output ffba_pkg::t_cmd    o_cmd
);
    ffba_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ffba_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_cmd.result = ffba_pkg::ST_OK;
        o_ready = 1'b0;
        o_valid = 1'b0;
        unique case (r_state)
            ffba_pkg::S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state = ffba_pkg::S_CHECK;
                end
            end
            ffba_pkg::S_CHECK: begin
                o_cmd.scan_start = 1'b1;
                if (i_stat.is_free) begin
                    n_state = ffba_pkg::S_SCAN_RD;
                end else if (i_stat.bad_size) begin
                    o_cmd.set_result = 1'b1;
                    o_cmd.result = ffba_pkg::ST_BAD_SIZE;
                    n_state = ffba_pkg::S_DONE;
                end else if (i_stat.too_big) begin
                    o_cmd.set_result = 1'b1;
                    o_cmd.result = ffba_pkg::ST_NO_SPACE;
                    n_state = ffba_pkg::S_DONE;
                end else if (i_stat.any_page) begin
                    n_state = ffba_pkg::S_SCAN_RD;
                end else begin
                    n_state = ffba_pkg::S_NEWPAGE;
                end
            end
            ffba_pkg::S_SCAN_RD: begin
                if (i_stat.scan_end) begin
                    if (i_stat.is_free) begin
                        o_cmd.set_result = 1'b1;
                        o_cmd.result = ffba_pkg::ST_NOT_ALLOC;
                        n_state = ffba_pkg::S_DONE;
                    end else begin
                        n_state = ffba_pkg::S_TAIL;
                    end
                end else begin
                    o_cmd.rd_scan = 1'b1;
                    n_state = ffba_pkg::S_SCAN_WAIT;
                end
            end
            ffba_pkg::S_SCAN_WAIT: begin
                o_cmd.eval = 1'b1;
                n_state = ffba_pkg::S_SCAN_EVAL;
            end
            ffba_pkg::S_SCAN_EVAL: begin
                if (i_stat.is_free) begin
                    if (i_stat.free_hit) begin
                        o_cmd.del_init = 1'b1;
                        n_state = ffba_pkg::S_SHIFT_RD;
                    end else begin
                        o_cmd.scan_next = 1'b1;
                        n_state = ffba_pkg::S_SCAN_RD;
                    end
                end else if (i_stat.gap_fit) begin
                    if (i_stat.full1) begin
                        o_cmd.set_result = 1'b1;
                        o_cmd.result = ffba_pkg::ST_NO_SPACE;
                        n_state = ffba_pkg::S_DONE;
                    end else begin
                        o_cmd.ins_init = 1'b1;
                        n_state = ffba_pkg::S_SHIFT_RD;
                    end
                end else begin
                    o_cmd.scan_next = 1'b1;
                    n_state = ffba_pkg::S_SCAN_RD;
                end
            end
            ffba_pkg::S_TAIL: begin
                if (i_stat.tail_fit) begin
                    if (i_stat.full1) begin
                        o_cmd.set_result = 1'b1;
                        o_cmd.result = ffba_pkg::ST_NO_SPACE;
                        n_state = ffba_pkg::S_DONE;
                    end else begin
                        n_state = ffba_pkg::S_PLACE;
                    end
                end else begin
                    n_state = ffba_pkg::S_NEWPAGE;
                end
            end
            ffba_pkg::S_NEWPAGE: begin
                if (i_stat.pages_full || i_stat.full2) begin
                    o_cmd.set_result = 1'b1;
                    o_cmd.result = ffba_pkg::ST_NO_SPACE;
                    n_state = ffba_pkg::S_DONE;
                end else begin
                    // marker goes at index count, block right after it
                    o_cmd.newpage = 1'b1;
                    o_cmd.wr_marker = 1'b1;
                    o_cmd.cnt_inc = 1'b1;
                    n_state = ffba_pkg::S_PLACE;
                end
            end
            ffba_pkg::S_SHIFT_RD: begin
                if (i_stat.is_free ? i_stat.del_done : i_stat.ins_done) begin
                    if (i_stat.is_free) begin
                        o_cmd.cnt_dec = 1'b1;
                        o_cmd.set_result = 1'b1;
                        o_cmd.result = ffba_pkg::ST_OK;
                        n_state = ffba_pkg::S_DONE;
                    end else begin
                        n_state = ffba_pkg::S_PLACE;
                    end
                end else begin
                    o_cmd.rd_shift = 1'b1;
                    n_state = ffba_pkg::S_SHIFT_WAIT;
                end
            end
            ffba_pkg::S_SHIFT_WAIT: begin
                // read data of the shift source is on the RAM output now
                o_cmd.eval = 1'b1;
                n_state = ffba_pkg::S_SHIFT_WR;
            end
            ffba_pkg::S_SHIFT_WR: begin
                o_cmd.wr_shift = 1'b1;
                o_cmd.shift_next = 1'b1;
                n_state = ffba_pkg::S_SHIFT_RD;
            end
            ffba_pkg::S_PLACE: begin
                o_cmd.wr_place = 1'b1;
                o_cmd.cnt_inc = 1'b1;
                o_cmd.set_result = 1'b1;
                o_cmd.result = ffba_pkg::ST_OK;
                n_state = ffba_pkg::S_DONE;
            end
            ffba_pkg::S_DONE: begin
                o_valid = 1'b1;
                if (i_ready) begin
                    n_state = ffba_pkg::S_IDLE;
                end
            end
            default: n_state = ffba_pkg::S_IDLE;
        endcase
    end
endmodule

### design/ffba_dp.sv
// Datapath: request registers, block table, scan pointer and page arithmetic
module ffba_dp #(
    parameter int TABLE_ENTRIES = ffba_pkg::TABLE_ENTRIES,
    parameter int PAGE_COUNT    = ffba_pkg::PAGE_COUNT,
    parameter longint PAGE_BYTES = ffba_pkg::PAGE_BYTES
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_opcode,
    input  logic [ffba_pkg::SIZE_W-1:0] i_alloc_size,
    input  logic [ffba_pkg::ADDR_W-1:0] i_free_address,
    input  ffba_pkg::t_cmd              i_cmd,
    output ffba_pkg::t_stat             o_stat,
    output logic [1:0]                  o_status,
    output logic [ffba_pkg::ADDR_W-1:0] o_block_address
);
    localparam int IW = $clog2(TABLE_ENTRIES);
    localparam int CW = $clog2(TABLE_ENTRIES + 1);
    localparam int PW = $clog2(PAGE_COUNT + 1);
    localparam int XW = ffba_pkg::XADDR_W;
    localparam int SW = ffba_pkg::SIZE_W;
    localparam int SZW = SW + 1;   // rounded size may reach 2^23
    localparam logic [XW-1:0] PB = XW'(PAGE_BYTES);

    logic          r_op;
    logic [SW-1:0] r_req;
    logic [XW-1:0] r_faddr;
    logic [CW-1:0] r_count;
    logic [PW-1:0] r_pages;
    logic [XW-1:0] r_pg_base;      // base of the next page to open, pages * PAGE_BYTES
    logic [CW-1:0] r_i, r_k;
    logic [XW-1:0] r_p;
    logic [XW-1:0] r_p_page_end;   // end of page holding p
    logic [XW-1:0] r_eb;
    logic [SW-1:0] r_el;
    logic [1:0]    r_status;
    logic [ffba_pkg::ADDR_W-1:0] r_addr;

    logic [SZW-1:0] size;
    assign size = (SZW'(r_req) + SZW'(7)) & ~SZW'(7);

    // table memory
    logic           we;
    logic [IW-1:0]  ma;
    logic [XW-1:0]  wb, rb;
    logic [SW-1:0]  wl, rl;

    always_comb begin
        we = i_cmd.wr_shift | i_cmd.wr_place | i_cmd.wr_marker;
        ma = r_i[IW-1:0];
        wb = r_p;
        wl = size[SW-1:0];
        if (i_cmd.rd_shift) begin
            ma = r_op ? IW'(r_k + CW'(1)) : IW'(r_k - CW'(1));
        end else if (i_cmd.wr_shift) begin
            ma = r_k[IW-1:0];
            wb = r_eb;
            wl = r_el;
        end else if (i_cmd.wr_marker) begin
            ma = r_count[IW-1:0];
            wb = r_pg_base;
            wl = '0;
        end else if (i_cmd.wr_place) begin
            ma = r_i[IW-1:0];
        end
    end

    ffba_ram #(.WIDTH(XW), .DEPTH(TABLE_ENTRIES)) u_base (
        .i_clk(i_clk), .i_we(we), .i_addr(ma), .i_wdata(wb), .o_rdata(rb));
    ffba_ram #(.WIDTH(SW), .DEPTH(TABLE_ENTRIES)) u_len (
        .i_clk(i_clk), .i_we(we), .i_addr(ma), .i_wdata(wl), .o_rdata(rl));

    // next page bounds for a new p: page end and open test via running compare
    logic [XW-1:0] p_next;
    assign p_next = r_eb + XW'(r_el);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_pages   <= '0;
            r_pg_base <= '0;
        end else begin
            if (i_cmd.cnt_inc && !i_cmd.cnt_dec) r_count <= r_count + CW'(1);
            if (i_cmd.cnt_dec) r_count <= r_count - CW'(1);
            if (i_cmd.newpage) begin
                r_pages   <= r_pages + PW'(1);
                r_pg_base <= r_pg_base + PB;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op    <= i_opcode;
            r_req   <= i_alloc_size;
            r_faddr <= XW'(i_free_address);
        end
        if (i_cmd.scan_start) begin
            r_i <= '0;
            r_p <= '0;
            r_p_page_end <= PB;
        end
        if (i_cmd.eval) begin
            r_eb <= rb;
            r_el <= rl;
        end
        if (i_cmd.scan_next) begin
            r_i <= r_i + CW'(1);
            r_p <= p_next;
            // page of p is found by walking page ends; entries only grow
            if (p_next >= r_p_page_end) begin
                r_p_page_end <= r_p_page_end + PB;
            end
        end
        if (i_cmd.newpage) begin
            r_p <= r_pg_base;
            r_i <= r_count + CW'(1);
        end
        if (i_cmd.ins_init) r_k <= r_count;
        if (i_cmd.del_init) r_k <= r_i;
        if (i_cmd.shift_next) r_k <= r_op ? r_k + CW'(1) : r_k - CW'(1);
        if (i_cmd.set_result) begin
            r_status <= i_cmd.result;
            r_addr <= (i_cmd.result == ffba_pkg::ST_OK && !r_op)
                      ? r_p[ffba_pkg::ADDR_W-1:0] : '0;
        end
    end

    // page-end register may lag one page behind a long jump; settle exactly
    logic [XW-1:0] pend;
    assign pend = (r_p >= r_p_page_end) ? r_p_page_end + PB : r_p_page_end;
    logic fits;
    assign fits = (r_p < r_pg_base) && (r_p + XW'(size) <= pend);

    assign o_stat.is_free    = r_op;
    assign o_stat.bad_size   = (r_req == '0) || (XW'(r_req) > PB);
    assign o_stat.too_big    = XW'(size) > PB;
    assign o_stat.any_page   = r_pages != '0;
    assign o_stat.scan_end   = r_i == r_count;
    assign o_stat.gap_fit    = (r_p + XW'(size) <= r_eb) && fits;
    assign o_stat.free_hit   = (r_eb == r_faddr) && (r_el != '0);
    assign o_stat.tail_fit   = fits;
    assign o_stat.full1      = r_count >= CW'(TABLE_ENTRIES);
    assign o_stat.full2      = r_count + CW'(2) > CW'(TABLE_ENTRIES);
    assign o_stat.pages_full = r_pages >= PW'(PAGE_COUNT);
    assign o_stat.ins_done   = r_k == r_i;
    assign o_stat.del_done   = (r_k + CW'(1)) >= r_count;

    assign o_status = r_status;
    assign o_block_address = r_addr;
endmodule

### design/first_fit_block_allocator_core.sv
// Top level: first-fit block allocator, controller plus datapath
//
//  channel | signals                                    | dir
//  request | i_valid o_ready, opcode alloc_size addr    | in
//  result  | o_valid i_ready, status block_address      | out
//
// One request at a time. Alloc scans the sorted table, each entry by a read,
// wait and evaluate state, then shifts entries up, each by read, wait and write;
// free scans and shifts down alike. Scan plus shift cover the table once, so the
// worst case grows with TABLE_ENTRIES, set by the single table RAM port.
// Reset clears controller state, count and page registers only; table RAM is not cleared.
// The result waits in its register until taken; no new request meanwhile.
`include "assert_macros.svh"
module first_fit_block_allocator_core #(
    parameter int TABLE_ENTRIES = ffba_pkg::TABLE_ENTRIES,
    parameter int PAGE_COUNT    = ffba_pkg::PAGE_COUNT,
    parameter longint PAGE_BYTES = ffba_pkg::PAGE_BYTES
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic                        i_opcode,
    input  logic [ffba_pkg::SIZE_W-1:0] i_alloc_size,
    input  logic [ffba_pkg::ADDR_W-1:0] i_free_address,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [1:0]                  o_status,
    output logic [ffba_pkg::ADDR_W-1:0] o_block_address
);
    ffba_pkg::t_cmd  cmd;
    ffba_pkg::t_stat stat;

    ffba_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_ready(o_ready),
        .o_valid(o_valid), .i_ready(i_ready),
        .i_stat(stat), .o_cmd(cmd));

    ffba_dp #(
        .TABLE_ENTRIES(TABLE_ENTRIES), .PAGE_COUNT(PAGE_COUNT),
        .PAGE_BYTES(PAGE_BYTES)
    ) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_opcode(i_opcode), .i_alloc_size(i_alloc_size),
        .i_free_address(i_free_address),
        .i_cmd(cmd), .o_stat(stat),
        .o_status(o_status), .o_block_address(o_block_address));

    `ASSERT_IMPL(a_no_overlap, i_clk, i_rst_n, o_valid, !o_ready, "ready while result held")
    `ASSERT_IMPL(a_addr_zero, i_clk, i_rst_n, o_valid && o_status != ffba_pkg::ST_OK,
                 o_block_address == '0, "address on failed request")
    `ASSERT_NEXT(a_result_next, i_clk, i_rst_n, o_valid && i_ready, o_ready,
                 "not idle after result taken")
endmodule
